// File: rtl/weighted_round_robin_joiner_core_macros.svh
// Assertion macros used by the joiner drain engine.
`ifndef WEIGHTED_ROUND_ROBIN_JOINER_CORE_MACROS_SVH
`define WEIGHTED_ROUND_ROBIN_JOINER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define WRRJ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("wrrj assertion failed");
// When the condition holds, the consequence must hold in the next cycle.
`define WRRJ_ASSERT_NEXT(lbl, clk, rstn, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
    else $error("wrrj assertion failed");
`else
`define WRRJ_ASSERT(lbl, clk, rstn, prop)
`define WRRJ_ASSERT_NEXT(lbl, clk, rstn, cond, cons)
`endif
`endif

// File: rtl/wrrj_pkg.sv
`timescale 1ns / 1ps
package wrrj_pkg;

  localparam int NUM_SOURCES_DEF = 4;
  localparam int FIFO_DEPTH_DEF  = 16;
  localparam int DATA_WIDTH_DEF  = 32;

  localparam int NUM_WEIGHTS = 4;
  localparam int WEIGHT_W    = 8;
  localparam int SRC_IDX_W   = 2;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 32;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SRC0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SRC1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SRC2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SRC3 = 2'd3;

  typedef struct packed {
    logic [SRC_IDX_W-1:0] source_index;
    logic [IN_DATA_W-1:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic [OUT_DATA_W-1:0] data_out;
    logic                  last_of_run;
    logic                  overflow_seen;
  } out_word_t;

  // Push command handed from the front end to the drain engine.
  typedef struct packed {
    logic                 src_ok;
    logic [SRC_IDX_W-1:0] source_index;
    logic [IN_DATA_W-1:0] data_in;
  } cmd_t;

endpackage

// File: rtl/weighted_round_robin_joiner_core.sv
`timescale 1ns / 1ps
// Path: a push waits in the front-end queue and is written to its source FIFO in S_IDLE; each
// released word is read from the store in S_CHECK and loaded into the output register in S_READ.
// A push releasing nothing passes S_IDLE and S_CHECK; the engine takes new pushes only in S_IDLE.
// Reset: rst_n is synchronous, active low; it clears pointers, fill counts, the current source,
// the taken count, the overflow flag and the queues, and sets every weight to 1.
// The word store itself is not cleared, since only pushed entries are ever read.
module weighted_round_robin_joiner_core
  import wrrj_pkg::*;
#(
  parameter int NUM_SOURCES = NUM_SOURCES_DEF,
  parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_word,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WEIGHT_W-1:0]  cfg_wdata
);

  // The front end takes each pushed word, tags whether its source exists,
  // and parks it in a two-entry queue. It keeps accepting while the drain
  // engine is busy releasing an earlier run, until the queue is full.
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  wrrj_front #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // The drain engine writes the word into its source's circular FIFO (or
  // flags an overflow), then walks the sources in weighted round-robin
  // order until the current source runs dry. Results leave through an
  // output register, so a stalled consumer only holds the engine in place.
  wrrj_back #(
    .NUM_SOURCES (NUM_SOURCES),
    .FIFO_DEPTH  (FIFO_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_word     (out_word)
  );

endmodule

// File: rtl/wrrj_ram.sv
`timescale 1ns / 1ps
module wrrj_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// File: rtl/wrrj_front.sv
`timescale 1ns / 1ps
module wrrj_front
  import wrrj_pkg::*;
#(
  parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_word,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  // Two-entry command queue.
  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       new_cmd;

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    new_cmd.src_ok       = (32'(in_word.source_index) < NUM_SOURCES);
    new_cmd.source_index = in_word.source_index;
    new_cmd.data_in      = in_word.data_in;
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/wrrj_back.sv
`timescale 1ns / 1ps
`include "weighted_round_robin_joiner_core_macros.svh"
module wrrj_back
  import wrrj_pkg::*;
#(
  parameter int NUM_SOURCES = NUM_SOURCES_DEF,
  parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  cmd_t                 cmd,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WEIGHT_W-1:0]  cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_word
);

  localparam int SRC_W   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int PTR_W   = $clog2(FIFO_DEPTH);
  localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam int ADDR_W  = SRC_W + PTR_W;
  localparam int STORE_W = (DATA_WIDTH < IN_DATA_W) ? DATA_WIDTH : IN_DATA_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_READ  = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [PTR_W-1:0]    wp_r   [NUM_SOURCES];
  logic [PTR_W-1:0]    wp_nxt [NUM_SOURCES];
  logic [PTR_W-1:0]    rp_r   [NUM_SOURCES];
  logic [PTR_W-1:0]    rp_nxt [NUM_SOURCES];
  logic [CNT_W-1:0]    fill_r   [NUM_SOURCES];
  logic [CNT_W-1:0]    fill_nxt [NUM_SOURCES];
  logic [SRC_W-1:0]    cur_r, cur_nxt;
  logic [WEIGHT_W-1:0] taken_r, taken_nxt;
  logic                overflow_flag_r, overflow_flag_nxt;
  logic [WEIGHT_W-1:0] weight_r [NUM_WEIGHTS];
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_word_r, out_word_nxt;

  logic [SRC_W-1:0]    src_idx;
  logic [SRC_W-1:0]    sel_idx;
  logic [SRC_W-1:0]    cur_next_src;
  logic [CNT_W-1:0]    fill_sel;
  logic [WEIGHT_W-1:0] weight_eff;
  logic [WEIGHT_W-1:0] taken_inc;
  logic                can_load;

  logic                ram_wr_en;
  logic [ADDR_W-1:0]   ram_wr_addr;
  logic                ram_rd_en;
  logic [ADDR_W-1:0]   ram_rd_addr;
  logic [STORE_W-1:0]  ram_rd_data;

  wrrj_ram #(
    .WIDTH (STORE_W),
    .DEPTH (2 ** ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (cmd.data_in[STORE_W-1:0]),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign cmd_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    src_idx      = SRC_W'(cmd.source_index);
    sel_idx      = (state_r == S_IDLE) ? src_idx : cur_r;
    fill_sel     = fill_r[sel_idx];
    cur_next_src = (cur_r == SRC_W'(NUM_SOURCES - 1)) ? '0 : cur_r + 1'b1;
    weight_eff   = 8'd1;
    if (32'(cur_r) < NUM_WEIGHTS) begin
      weight_eff = weight_r[2'(cur_r)];
    end
    if (weight_eff == '0) begin
      weight_eff = 8'd1;
    end
    taken_inc = taken_r + 1'b1;
    can_load  = !out_valid_r || out_ready;

    state_nxt         = state_r;
    wp_nxt            = wp_r;
    rp_nxt            = rp_r;
    fill_nxt          = fill_r;
    cur_nxt           = cur_r;
    taken_nxt         = taken_r;
    overflow_flag_nxt = overflow_flag_r;
    out_valid_nxt     = (out_valid_r && !out_ready);
    out_word_nxt      = out_word_r;
    ram_wr_en         = 1'b0;
    ram_wr_addr       = {src_idx, wp_r[src_idx]};
    ram_rd_en         = 1'b0;
    ram_rd_addr       = {cur_r, rp_r[cur_r]};

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.src_ok) begin
            if (fill_sel == CNT_W'(FIFO_DEPTH)) begin
              overflow_flag_nxt = 1'b1;
            end else begin
              ram_wr_en         = 1'b1;
              wp_nxt[src_idx]   = (wp_r[src_idx] == PTR_W'(FIFO_DEPTH - 1)) ?
                                  '0 : wp_r[src_idx] + 1'b1;
              fill_nxt[src_idx] = fill_sel + 1'b1;
            end
          end
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (fill_sel == '0) begin
          state_nxt = S_IDLE;
        end else begin
          ram_rd_en       = 1'b1;
          rp_nxt[cur_r]   = (rp_r[cur_r] == PTR_W'(FIFO_DEPTH - 1)) ?
                            '0 : rp_r[cur_r] + 1'b1;
          fill_nxt[cur_r] = fill_sel - 1'b1;
          if (taken_inc >= weight_eff) begin
            taken_nxt = '0;
            cur_nxt   = cur_next_src;
          end else begin
            taken_nxt = taken_inc;
          end
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // cur_r already names the source to drain next, so an empty FIFO
        // there means this word closes the run.
        if (can_load) begin
          out_valid_nxt              = 1'b1;
          out_word_nxt.data_out      = OUT_DATA_W'(ram_rd_data);
          out_word_nxt.last_of_run   = (fill_sel == '0);
          out_word_nxt.overflow_seen = overflow_flag_r;
          state_nxt = (fill_sel == '0) ? S_IDLE : S_CHECK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    if (!rst_n) begin
      state_r         <= S_IDLE;
      cur_r           <= '0;
      taken_r         <= '0;
      overflow_flag_r <= 1'b0;
      out_valid_r     <= 1'b0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        wp_r[i]   <= '0;
        rp_r[i]   <= '0;
        fill_r[i] <= '0;
      end
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        weight_r[i] <= 8'd1;
      end
    end else begin
      state_r         <= state_nxt;
      cur_r           <= cur_nxt;
      taken_r         <= taken_nxt;
      overflow_flag_r <= overflow_flag_nxt;
      out_valid_r     <= out_valid_nxt;
      wp_r            <= wp_nxt;
      rp_r            <= rp_nxt;
      fill_r          <= fill_nxt;
      if (cfg_write_en) begin
        case (cfg_index)
          REG_WEIGHT_SRC0: weight_r[0] <= cfg_wdata;
          REG_WEIGHT_SRC1: weight_r[1] <= cfg_wdata;
          REG_WEIGHT_SRC2: weight_r[2] <= cfg_wdata;
          REG_WEIGHT_SRC3: weight_r[3] <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  `WRRJ_ASSERT(a_fill_bound, clk, rst_n, fill_r[cur_r] <= CNT_W'(FIFO_DEPTH))
  `WRRJ_ASSERT_NEXT(a_overflow_sticky, clk, rst_n, overflow_flag_r, overflow_flag_r)
  `WRRJ_ASSERT_NEXT(a_read_then_load, clk, rst_n, ram_rd_en, state_r == S_READ)
  `WRRJ_ASSERT_NEXT(a_load_from_read, clk, rst_n, !out_valid_r && state_r != S_READ, !out_valid_r)

endmodule

// File: tb/weighted_round_robin_joiner_core_test.sv
`timescale 1ns / 1ps
module weighted_round_robin_joiner_core_test;
  import wrrj_pkg::*;

  // A pushed word that causes results raises out_valid after the front-end queue and the
  // engine's write, read and load states; a push that releases nothing keeps the engine
  // busy. The settle time covers both before any weight is rewritten or the run ends.
  localparam int SETTLE_CYCLES  = 16;
  // The receiver holds off this long once, so that the block backs up into its input.
  localparam int RX_HOLD_CYCLES = 400;
  // The run is declared hung after this many cycles in which no word moves on either side and no weight is written.
  localparam int STALL_LIMIT    = 5000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_word;
  logic                 cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WEIGHT_SRC0;
  logic [WEIGHT_W-1:0]  cfg_wdata = '0;

  weighted_round_robin_joiner_core u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_word     (out_word),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted joiner state. Each source keeps its own queue of stored words, never deeper
  // than the hardware FIFO; the round-robin pointer, the count of words taken from the
  // current source and the sticky overflow flag follow the block word by word.
  logic [IN_DATA_W-1:0] source_fifo [NUM_SOURCES_DEF][$];
  logic [SRC_IDX_W-1:0] rr_source = '0;
  logic [WEIGHT_W-1:0]  rr_taken = '0;
  logic                 sticky_overflow = 1'b0;
  logic [WEIGHT_W-1:0]  weight_reg [NUM_WEIGHTS] = '{default: 8'd1};

  // Words waiting to be offered, and results that the block still owes us.
  in_word_t  pending_words [$];
  out_word_t expected_words [$];

  int words_queued   = 0;
  int words_accepted = 0;
  int error_count    = 0;
  int stall_cycles   = 0;

  // Idle pattern state for both sides.
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  int tx_gap = 0;
  int rx_gap = 0;
  bit rx_hold_req = 1'b0;
  bit rx_hold_taken = 1'b0;
  int rx_hold_left = 0;

  // Most picks give no gap or a short one; now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Stores one pushed word and works out every word that the round-robin drain releases.
  // The drain walks from the current source, taking up to its weight (zero counts as one)
  // before moving on, and stops at the first source whose queue is empty. A push into a
  // full queue is lost and sets the overflow flag for the rest of the run.
  task automatic predict_release(input in_word_t pushed);
    out_word_t      held;
    bit             have_held;
    logic [WEIGHT_W-1:0] limit;
    have_held = 1'b0;
    if (source_fifo[pushed.source_index].size() >= FIFO_DEPTH_DEF) begin
      sticky_overflow = 1'b1;
    end else begin
      source_fifo[pushed.source_index].insert(source_fifo[pushed.source_index].size(),
                                              pushed.data_in);
    end
    while (source_fifo[rr_source].size() != 0) begin
      if (have_held) begin
        expected_words.insert(expected_words.size(), held);
      end
      held.data_out      = source_fifo[rr_source].pop_front();
      held.last_of_run   = 1'b0;
      held.overflow_seen = sticky_overflow;
      have_held = 1'b1;
      limit = (weight_reg[rr_source] == '0) ? 8'd1 : weight_reg[rr_source];
      rr_taken = rr_taken + 8'd1;
      // A weight lowered below the running count makes the drain move on right here.
      if (rr_taken >= limit) begin
        rr_taken  = '0;
        rr_source = rr_source + 2'd1;
      end
    end
    if (have_held) begin
      held.last_of_run = 1'b1;
      expected_words.insert(expected_words.size(), held);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    error_count++;
    if (error_count <= 10) begin
      $display("MISMATCH %s: expected %h, got %h", what, want, got);
    end
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("word with nothing expected, data_out", '0, got.data_out);
    end else begin
      want = expected_words.pop_front();
      if (got.data_out !== want.data_out) begin
        report_mismatch("data_out", want.data_out, got.data_out);
      end
      if (got.last_of_run !== want.last_of_run) begin
        report_mismatch("last_of_run", want.last_of_run, got.last_of_run);
      end
      if (got.overflow_seen !== want.overflow_seen) begin
        report_mismatch("overflow_seen", want.overflow_seen, got.overflow_seen);
      end
    end
  endtask

  // Driver. An offered word stays on the port until it is taken; only then may a gap
  // follow or the next pending word be loaded. The prediction runs at the accepting edge,
  // well ahead of the earliest result that the word can cause.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_release(in_word);
        words_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          in_valid <= 1'b0;
          tx_gap--;
        end else if (pending_words.size() != 0) begin
          in_valid <= 1'b1;
          in_word  <= pending_words.pop_front();
          tx_gap = tx_idle_en ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Checks every accepted result against the oldest expectation and drives
  // out_ready with random gaps. The one long hold-off is counted here as well.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_result(out_word);
      end
      if (rx_hold_req && !rx_hold_taken) begin
        rx_hold_taken = 1'b1;
        rx_hold_left  = RX_HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else if (rx_gap > 0) begin
        out_ready <= 1'b0;
        rx_gap--;
      end else begin
        out_ready <= 1'b1;
        rx_gap = rx_idle_en ? pick_gap() : 0;
      end
    end
  end

  // Watchdog: any movement on the input, the output or the register port restarts it.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_word(input logic [SRC_IDX_W-1:0] src, input logic [IN_DATA_W-1:0] data);
    in_word_t w;
    w.source_index = src;
    w.data_in      = data;
    pending_words.insert(pending_words.size(), w);
    words_queued++;
  endtask

  // Queues random pushes. A share of them can be steered to one source, which lets the
  // taken count climb under large weights and lets other sources pile up words.
  task automatic queue_random(input int count, input logic [SRC_IDX_W-1:0] favored,
                              input int favored_pct);
    logic [SRC_IDX_W-1:0] src;
    for (int i = 0; i < count; i++) begin
      src = ($urandom_range(0, 99) < favored_pct) ? favored : SRC_IDX_W'($urandom_range(0, 3));
      push_word(src, $urandom());
    end
  endtask

  // The sender stops here until every pushed word is taken and every result has come,
  // then lets the drain engine settle.
  task automatic wait_drained();
    while (words_accepted != words_queued || expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] value);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_wdata    <= value;
    weight_reg[idx] = value;
  endtask

  // Only called while the block is idle, so the predictor may take the new weights at once.
  task automatic write_weights(input logic [WEIGHT_W-1:0] w0, input logic [WEIGHT_W-1:0] w1,
                               input logic [WEIGHT_W-1:0] w2, input logic [WEIGHT_W-1:0] w3);
    write_reg(REG_WEIGHT_SRC0, w0);
    write_reg(REG_WEIGHT_SRC1, w1);
    write_reg(REG_WEIGHT_SRC2, w2);
    write_reg(REG_WEIGHT_SRC3, w3);
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset weights of one. The first four pushes walk the
    // round robin through all sources with the extreme data values, including a push
    // that waits in its queue and is released later by another source's push.
    push_word(2'd0, 32'h0000_0000);
    push_word(2'd2, 32'hFFFF_FFFF);
    push_word(2'd1, 32'hA5A5_A5A5);
    push_word(2'd3, 32'h5A5A_5A5A);
    // Source 0 is current and empty, so source 2 fills up; the seventeenth push finds
    // its queue full, is lost and sets the sticky overflow flag.
    for (int i = 0; i < 17; i++) begin
      push_word(2'd2, 32'h1000_0000 + i);
    end
    // These release one word from each source in turn once source 0 has something.
    push_word(2'd1, 32'h8000_0001);
    push_word(2'd3, 32'h7FFF_FFFE);
    push_word(2'd0, 32'hDEAD_BEEF);
    wait_drained();

    // A zero weight, the largest weight and small ones, with idling on both sides.
    tx_idle_en <= 1'b1;
    rx_idle_en <= 1'b1;
    write_weights(8'd0, 8'd255, 8'd1, 8'd3);
    queue_random(16, 2'd1, 30);
    wait_drained();

    // Largest weights everywhere, mostly source 0, no idling at all.
    tx_idle_en <= 1'b0;
    rx_idle_en <= 1'b0;
    write_weights(8'd255, 8'd255, 8'd255, 8'd255);
    queue_random(12, 2'd0, 60);
    wait_drained();

    // Weights lowered below the running count. The receiver holds off for a long
    // stretch while the sender keeps offering, so the block backs up into its input.
    write_weights(8'd2, 8'd0, 8'd7, 8'd1);
    rx_hold_req <= 1'b1;
    queue_random(20, 2'd0, 0);
    wait_drained();

    // Random weights with idling on both sides.
    tx_idle_en <= 1'b1;
    rx_idle_en <= 1'b1;
    write_weights(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    queue_random(16, 2'd3, 25);
    wait_drained();

    // Mixed extremes, receiver idling only.
    tx_idle_en <= 1'b0;
    write_weights(8'd255, 8'd0, 8'd0, 8'd255);
    queue_random(12, 2'd2, 20);
    wait_drained();

    error_count += expected_words.size();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
